// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;
  localparam int unsigned MAX_REPLACE_DEF = 8;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN   = 2'd3;

  // input item kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PASS,
    ST_FLUSH,
    ST_REPL
  } sfr_state_e;

  typedef enum logic [1:0] {
    EMIT_HOLD,
    EMIT_IN,
    EMIT_REPL
  } sfr_emit_e;

  typedef struct packed {
    logic      load_in;
    logic      append;
    logic      drop;
    logic      clear;
    logic      rep_start;
    logic      rep_step;
    logic      emit;
    sfr_emit_e emit_sel;
    logic      emit_last;
  } sfr_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic drop_now;
    logic match_now;
    logic last_drop;
    logic plen_zero;
    logic rlen_zero;
    logic rep_last;
    logic out_free;
  } sfr_stat_t;

endpackage

// ----- rtl/sfr_if.sv -----
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the stream find-and-replace block.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- rtl/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a byte text with a held-prefix buffer.
// ----------------------------------------------------------------------------
// Text enters one word per item (kind 0 = byte, kind 1 = end of text) and
// every leftmost, non-overlapping occurrence of the pattern is replaced.
// One item is worked at a time: once it is accepted, each output word goes
// through the single output register, and a run of released bytes ends with
// a further compare of what is still held. The sink's ready stalls the
// sequencer one word at a time. Writing the pattern or its length drops any
// held bytes; the user must write configuration only while the block is
// idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned MAX_REPLACE = MAX_REPLACE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfr_in_if.sink                in_i,
  sfr_out_if.source             out_o
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_i.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last)
  );

endmodule

// ----- rtl/sfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer: accepts a word, then walks the pass, release, flush and
// replacement phases one output word per cycle while the output is free.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  input  sfr_stat_t stat_i,
  output sfr_cmd_t  cmd_o
);

  sfr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_sel = EMIT_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (in_kind_i == KIND_END) begin
            state_d = ST_FLUSH;
          end else if (stat_i.plen_zero) begin
            state_d = ST_PASS;
          end else begin
            cmd_o.append = 1'b1;
            state_d      = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat_i.drop_now) begin
          // release the front byte, the rest is checked next cycle
          if (stat_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_sel  = EMIT_HOLD;
            cmd_o.emit_last = stat_i.last_drop;
            cmd_o.drop      = 1'b1;
          end
        end else if (stat_i.match_now) begin
          cmd_o.clear = 1'b1;
          if (!stat_i.rlen_zero) begin
            cmd_o.rep_start = 1'b1;
            state_d         = ST_REPL;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_IN;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat_i.cnt_zero) begin
          // empty pattern appends the replacement at end of text
          if (stat_i.plen_zero && !stat_i.rlen_zero) begin
            cmd_o.rep_start = 1'b1;
            state_d         = ST_REPL;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_HOLD;
          cmd_o.emit_last = stat_i.cnt_one && !(stat_i.plen_zero && !stat_i.rlen_zero);
          cmd_o.drop      = 1'b1;
        end
      end
      ST_REPL: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_REPL;
          cmd_o.emit_last = stat_i.rep_last;
          cmd_o.rep_step  = 1'b1;
          if (stat_i.rep_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sfr_datapath.sv -----
// ----------------------------------------------------------------------------
// sfr_datapath
// Configuration registers, hold buffer with prefix compare, replacement
// index and the output register.
// ----------------------------------------------------------------------------
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned MAX_REPLACE = MAX_REPLACE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [BYTE_W-1:0]     in_byte_i,
  input  sfr_cmd_t              cmd_i,
  output sfr_stat_t             stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  out_last_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned RCNT_W = $clog2(MAX_REPLACE + 1);
  localparam int unsigned RIDX_W = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  logic [CFG_DATA_W-1:0] pattern_bytes_q, replace_bytes_q;
  logic [LEN_W-1:0]      pattern_len_q, replace_len_q;

  logic [BYTE_W-1:0] hold_q [MAX_PATTERN];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic [RIDX_W-1:0] ri_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  plen;
  logic [RCNT_W-1:0] rlen;
  logic [CNT_W-1:0]  cnt_m1;
  logic              prefix_now, prefix_shift;
  logic              drop_next, match_next;
  logic              cfg_clear;
  logic [BYTE_W-1:0] emit_byte;

  // lengths above the buffer size are clamped
  assign plen = (pattern_len_q > LEN_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                     : pattern_len_q[CNT_W-1:0];
  assign rlen = (replace_len_q > LEN_W'(MAX_REPLACE)) ? RCNT_W'(MAX_REPLACE)
                                                     : replace_len_q[RCNT_W-1:0];

  assign cfg_clear = cfg_we_i && (cfg_index_i == CFG_PATTERN_BYTES ||
                                  cfg_index_i == CFG_PATTERN_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q <= '0;
      pattern_len_q   <= '0;
      replace_bytes_q <= '0;
      replace_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_BYTES: pattern_bytes_q <= cfg_data_i;
        CFG_PATTERN_LEN:   pattern_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACE_BYTES: replace_bytes_q <= cfg_data_i;
        CFG_REPLACE_LEN:   replace_len_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // held run against the pattern, as it stands and with the front dropped
  always_comb begin
    prefix_now   = 1'b1;
    prefix_shift = 1'b1;
    for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < cnt_q && hold_q[i] != pattern_bytes_q[BYTE_W*i +: BYTE_W]) begin
        prefix_now = 1'b0;
      end
    end
    for (int unsigned i = 0; i + 1 < MAX_PATTERN; i++) begin
      if (CNT_W'(i + 1) < cnt_q &&
          hold_q[i+1] != pattern_bytes_q[BYTE_W*i +: BYTE_W]) begin
        prefix_shift = 1'b0;
      end
    end
  end

  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign drop_next  = (cnt_m1 != '0) && ((cnt_m1 > plen) || !prefix_shift);
  assign match_next = (cnt_m1 == plen);

  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_one   = (cnt_q == CNT_W'(1));
  assign stat_o.drop_now  = (cnt_q != '0) && ((cnt_q > plen) || !prefix_now);
  assign stat_o.match_now = (cnt_q == plen);
  assign stat_o.last_drop = !drop_next && !(match_next && (rlen != '0));
  assign stat_o.plen_zero = (plen == '0);
  assign stat_o.rlen_zero = (rlen == '0);
  assign stat_o.rep_last  = ((RCNT_W'(ri_q) + RCNT_W'(1)) == rlen);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_clear || cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.drop) begin
      cnt_d = cnt_m1;
    end else if (cmd_i.append) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drop) begin
      for (int unsigned i = 0; i + 1 < MAX_PATTERN; i++) begin
        hold_q[i] <= hold_q[i+1];
      end
    end else if (cmd_i.append) begin
      hold_q[cnt_q[IDX_W-1:0]] <= in_byte_i;
    end
    if (cmd_i.load_in) begin
      in_byte_q <= in_byte_i;
    end
    if (cmd_i.rep_start) begin
      ri_q <= '0;
    end else if (cmd_i.rep_step) begin
      ri_q <= ri_q + RIDX_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.emit_sel)
      EMIT_IN:   emit_byte = in_byte_q;
      EMIT_REPL: emit_byte = replace_bytes_q[BYTE_W*ri_q +: BYTE_W];
      default:   emit_byte = hold_q[0];
    endcase
  end

  // output register parts the sequencer from the sink
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
